// ===== rtl/ilh_pkg.sv =====
// Shared types, constants and helper functions for the I/O layout log2 histogram unit.
package ilh_pkg;

    localparam int SECT_W   = 48;
    localparam int CNT_W    = 32;
    localparam int BIN_W    = 6;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_EVENT   = 2'd0,
        REQ_RD_SIZE = 2'd1,
        REQ_RD_GAP  = 2'd2,
        REQ_CLEAR   = 2'd3
    } req_kind_t;

    // Scalar statistics as they stand after a request.
    typedef struct packed {
        logic [CNT_W-1:0]  sync_count;
        logic [CNT_W-1:0]  fua_count;
        logic [SECT_W-1:0] origin_sector;
        logic [SECT_W-1:0] peak_sector;
        logic              seen_any;
    } snap_t;

    // First pipeline stage contents.
    typedef struct packed {
        logic              valid;
        req_kind_t         kind;
        logic [BIN_W-1:0]  bin_index;
        logic [SECT_W-1:0] len;
        logic [SECT_W-1:0] gap;
        logic              gap_pos;
        snap_t             snap;
    } s1_t;

    // Operation applied to a histogram bank at its read-modify-write stage.
    typedef struct packed {
        logic inc;
        logic clr;
    } bank_op_t;

    // Position of the highest set bit; zero for an input of zero or one.
    function automatic logic [BIN_W-1:0] floor_log2(input logic [SECT_W-1:0] v);
        logic [BIN_W-1:0] r;
        r = '0;
        for (int i = 1; i < SECT_W; i++)
        begin
            if (v[i])
            begin
                r = BIN_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage

// ===== rtl/io_layout_log2_histogram_unit.sv =====
// Top level of the I/O layout log2 histogram unit: bin selection, histogram banks and result queue.
//
//  channel   | direction | tdata / tuser contents
//  ----------+-----------+-------------------------------------------------------------
//  s_axis    | in        | one request: event, size bin read, gap bin read or clear
//  m_axis    | out       | one result per request: bin count and running statistics
//
// One request is accepted per cycle while s_axis_tready is high; its result passes
// the front stage and the bank read-modify-write stage, then enters the result queue.
// The per-cycle rate is set by the single read-modify-write port of each histogram
// memory, with forwarding between back-to-back updates of the same bin. Reset and a clear
// request empty the histograms at once through per-bin valid bits, so no clearing pass
// follows. Downstream stalls fill a four-entry result queue; s_axis_tready is low while
// queued plus in-flight results already number four.
module io_layout_log2_histogram_unit #(
    parameter int SIZE_BINS = 32,
    parameter int GAP_BINS  = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // start_sector[47:0], end_sector[95:48], is_sync[96], is_fua[97], bin_index[103:98]
    input  logic [103:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // bin_count[31:0], sync_count[63:32], fua_count[95:64], origin_sector[143:96],
    // peak_sector[191:144], seen_any[192], zero pad[199:193]
    output logic [199:0] m_axis_tdata
);

    localparam int SIZE_AW = $clog2(SIZE_BINS);
    localparam int GAP_AW  = $clog2(GAP_BINS);
    localparam int RES_W   = 200;
    localparam int PAD_W   = RES_W - (3 * ilh_pkg::CNT_W + 2 * ilh_pkg::SECT_W + 1);

    localparam logic [ilh_pkg::BIN_W:0] SIZE_TOP = (ilh_pkg::BIN_W + 1)'(SIZE_BINS - 1);
    localparam logic [ilh_pkg::BIN_W:0] GAP_TOP  = (ilh_pkg::BIN_W + 1)'(GAP_BINS - 1);

    logic                          accept;
    ilh_pkg::s1_t                  s1;
    logic [ilh_pkg::BIN_W:0]       size_log;
    logic [ilh_pkg::BIN_W:0]       gap_log;
    logic [ilh_pkg::BIN_W:0]       size_bin;
    logic [ilh_pkg::BIN_W:0]       gap_bin;
    logic [SIZE_AW-1:0]            size_addr;
    logic [GAP_AW-1:0]             gap_addr;
    logic                          size_ok;
    logic                          gap_ok;

    logic                          s2_valid_reg;
    ilh_pkg::req_kind_t            s2_kind_reg;
    logic                          s2_size_rd_reg;
    logic                          s2_gap_rd_reg;
    ilh_pkg::snap_t                s2_snap_reg;

    ilh_pkg::bank_op_t             size_op;
    ilh_pkg::bank_op_t             gap_op;
    logic [ilh_pkg::CNT_W-1:0]     size_value;
    logic [ilh_pkg::CNT_W-1:0]     gap_value;
    logic [ilh_pkg::CNT_W-1:0]     bin_count;
    logic [RES_W-1:0]              result;
    logic [ilh_pkg::OQ_CW-1:0]     oq_count;
    logic [ilh_pkg::OQ_CW-1:0]     pending;

    // Every request in the pipeline will need a queue slot, so count them before accepting.
    assign pending = oq_count + ilh_pkg::OQ_CW'(s1.valid) + ilh_pkg::OQ_CW'(s2_valid_reg);
    assign s_axis_tready = (pending < ilh_pkg::OQ_CW'(ilh_pkg::OQ_DEPTH));
    assign accept = s_axis_tvalid && s_axis_tready;

    ilh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (ilh_pkg::req_kind_t'(s_axis_tuser)),
        .start_sec (s_axis_tdata[47:0]),
        .end_sec   (s_axis_tdata[95:48]),
        .is_sync   (s_axis_tdata[96]),
        .is_fua    (s_axis_tdata[97]),
        .bin_index (s_axis_tdata[103:98]),
        .s1        (s1)
    );

    // Bin selection for the request in the first stage; the banks read at these addresses.
    always_comb
    begin
        size_log = {1'b0, ilh_pkg::floor_log2(s1.len)};
        gap_log  = s1.gap_pos ? ({1'b0, ilh_pkg::floor_log2(s1.gap)} + 1'b1) : '0;
        size_bin = (size_log > SIZE_TOP) ? SIZE_TOP : size_log;
        gap_bin  = (gap_log > GAP_TOP) ? GAP_TOP : gap_log;
        size_ok  = ({1'b0, s1.bin_index} <= SIZE_TOP);
        gap_ok   = ({1'b0, s1.bin_index} <= GAP_TOP);
        if (s1.kind == ilh_pkg::REQ_EVENT)
        begin
            size_addr = size_bin[SIZE_AW-1:0];
            gap_addr  = gap_bin[GAP_AW-1:0];
        end
        else
        begin
            size_addr = s1.bin_index[SIZE_AW-1:0];
            gap_addr  = s1.bin_index[GAP_AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_kind_reg    <= s1.kind;
        s2_size_rd_reg <= (s1.kind == ilh_pkg::REQ_RD_SIZE) && size_ok;
        s2_gap_rd_reg  <= (s1.kind == ilh_pkg::REQ_RD_GAP) && gap_ok;
        s2_snap_reg    <= s1.snap;
    end

    always_comb
    begin
        size_op.inc = s2_valid_reg && (s2_kind_reg == ilh_pkg::REQ_EVENT);
        size_op.clr = s2_valid_reg && (s2_kind_reg == ilh_pkg::REQ_CLEAR);
        gap_op      = size_op;
    end

    ilh_bank #(
        .DEPTH (SIZE_BINS),
        .AW    (SIZE_AW)
    ) u_size_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (size_addr),
        .op      (size_op),
        .value   (size_value)
    );

    ilh_bank #(
        .DEPTH (GAP_BINS),
        .AW    (GAP_AW)
    ) u_gap_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (gap_addr),
        .op      (gap_op),
        .value   (gap_value)
    );

    always_comb
    begin
        if (s2_size_rd_reg)
        begin
            bin_count = size_value;
        end
        else if (s2_gap_rd_reg)
        begin
            bin_count = gap_value;
        end
        else
        begin
            bin_count = '0;
        end
        result = {PAD_W'(0),
                  s2_snap_reg.seen_any,
                  s2_snap_reg.peak_sector,
                  s2_snap_reg.origin_sector,
                  s2_snap_reg.fua_count,
                  s2_snap_reg.sync_count,
                  bin_count};
    end

    ilh_outq #(
        .W (RES_W)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .push_data (result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .count     (oq_count)
    );

endmodule

// ===== rtl/ilh_front.sv =====
// Scalar statistics and the first pipeline stage: lengths, gaps and running sector bounds.
module ilh_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  ilh_pkg::req_kind_t          kind,
    input  logic [ilh_pkg::SECT_W-1:0]  start_sec,
    input  logic [ilh_pkg::SECT_W-1:0]  end_sec,
    input  logic                        is_sync,
    input  logic                        is_fua,
    input  logic [ilh_pkg::BIN_W-1:0]   bin_index,
    output ilh_pkg::s1_t                s1
);

    logic                        started_reg,  started_next;
    logic [ilh_pkg::SECT_W-1:0]  furthest_reg, furthest_next;
    logic [ilh_pkg::SECT_W-1:0]  first_reg,    first_next;
    logic [ilh_pkg::CNT_W-1:0]   sync_reg,     sync_next;
    logic [ilh_pkg::CNT_W-1:0]   fua_reg,      fua_next;
    logic                        s1_valid_reg;
    ilh_pkg::s1_t                s1_reg,       s1_next;
    logic [ilh_pkg::SECT_W-1:0]  eff_end;
    logic [ilh_pkg::SECT_W-1:0]  eff_first;

    // The first request since a clear acts as if the furthest end were its own end.
    assign eff_end   = started_reg ? furthest_reg : end_sec;
    assign eff_first = started_reg ? first_reg : start_sec;

    always_comb
    begin
        started_next  = started_reg;
        furthest_next = furthest_reg;
        first_next    = first_reg;
        sync_next     = sync_reg;
        fua_next      = fua_reg;
        unique case (kind)
            ilh_pkg::REQ_EVENT:
            begin
                started_next  = 1'b1;
                first_next    = eff_first;
                furthest_next = (end_sec > eff_end) ? end_sec : eff_end;
                if (is_sync)
                begin
                    sync_next = ilh_pkg::sat_inc(sync_reg);
                end
                if (is_fua)
                begin
                    fua_next = ilh_pkg::sat_inc(fua_reg);
                end
            end
            ilh_pkg::REQ_CLEAR:
            begin
                started_next  = 1'b0;
                furthest_next = '0;
                first_next    = '0;
                sync_next     = '0;
                fua_next      = '0;
            end
            default:
            begin
            end
        endcase

        s1_next                    = '0;
        s1_next.valid              = 1'b1;
        s1_next.kind               = kind;
        s1_next.bin_index          = bin_index;
        s1_next.len                = end_sec - start_sec;
        s1_next.gap                = start_sec - eff_end;
        s1_next.gap_pos            = start_sec > eff_end;
        s1_next.snap.sync_count    = sync_next;
        s1_next.snap.fua_count     = fua_next;
        s1_next.snap.origin_sector = first_next;
        s1_next.snap.peak_sector   = furthest_next;
        s1_next.snap.seen_any      = started_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg  <= 1'b0;
            furthest_reg <= '0;
            first_reg    <= '0;
            sync_reg     <= '0;
            fua_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                started_reg  <= started_next;
                furthest_reg <= furthest_next;
                first_reg    <= first_next;
                sync_reg     <= sync_next;
                fua_reg      <= fua_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    always_comb
    begin
        s1       = s1_reg;
        s1.valid = s1_valid_reg;
    end

endmodule

// ===== rtl/ilh_bank.sv =====
// One histogram bank: synchronous memory with valid bits, saturating read-modify-write and forwarding.
module ilh_bank #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [AW-1:0]              rd_addr,
    input  ilh_pkg::bank_op_t          op,
    output logic [ilh_pkg::CNT_W-1:0]  value
);

    logic [ilh_pkg::CNT_W-1:0] mem [DEPTH];
    logic [ilh_pkg::CNT_W-1:0] rdata_reg;
    logic [AW-1:0]             addr_reg;
    logic [DEPTH-1:0]          vld_reg;
    logic                      fwd_v_reg;
    logic [AW-1:0]             fwd_addr_reg;
    logic [ilh_pkg::CNT_W-1:0] fwd_data_reg;
    logic [ilh_pkg::CNT_W-1:0] cur;
    logic [ilh_pkg::CNT_W-1:0] inc_val;

    // The write of the previous request lands at the same edge as this read, so it is forwarded.
    // An entry whose valid bit is clear has not been written since the last clear and reads as zero.
    always_comb
    begin
        if (fwd_v_reg && (fwd_addr_reg == addr_reg))
        begin
            cur = fwd_data_reg;
        end
        else if (vld_reg[addr_reg])
        begin
            cur = rdata_reg;
        end
        else
        begin
            cur = '0;
        end
    end

    assign inc_val = ilh_pkg::sat_inc(cur);
    assign value   = cur;

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[rd_addr];
        addr_reg  <= rd_addr;
        if (op.inc)
        begin
            mem[addr_reg] <= inc_val;
        end
        fwd_addr_reg <= addr_reg;
        fwd_data_reg <= inc_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            fwd_v_reg <= 1'b0;
        end
        else if (op.clr)
        begin
            vld_reg   <= '0;
            fwd_v_reg <= 1'b0;
        end
        else
        begin
            fwd_v_reg <= op.inc;
            if (op.inc)
            begin
                vld_reg[addr_reg] <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/ilh_outq.sv =====
// Four-entry result queue that decouples the pipeline from the downstream ready.
module ilh_outq #(
    parameter int W = 200
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic [W-1:0]              push_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [W-1:0]              out_data,
    output logic [ilh_pkg::OQ_CW-1:0] count
);

    logic [W-1:0]              mem [ilh_pkg::OQ_DEPTH];
    logic [ilh_pkg::OQ_AW-1:0] wr_ptr_reg;
    logic [ilh_pkg::OQ_AW-1:0] rd_ptr_reg;
    logic [ilh_pkg::OQ_CW-1:0] count_reg;
    logic                      pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign count     = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== test/tb_io_layout_log2_histogram_unit.sv =====
// Self-checking testbench for the I/O layout log2 histogram unit: directed table, then mostly sorted random traffic.
`timescale 1ns / 100ps

module tb_io_layout_log2_histogram_unit;

    localparam int SIZE_BINS   = 32;
    localparam int GAP_BINS    = 64;
    localparam int RAND_CHUNKS = 30;
    localparam int CHUNK_LEN   = 61;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PRINT_LIMIT = 40;

    localparam int SECT_W = ilh_pkg::SECT_W;
    localparam int CNT_W  = ilh_pkg::CNT_W;
    localparam int BIN_W  = ilh_pkg::BIN_W;

    typedef struct packed {
        ilh_pkg::req_kind_t kind;
        logic [SECT_W-1:0]  start_lba;
        logic [SECT_W-1:0]  stop_lba;
        logic               is_sync;
        logic               is_fua;
        logic [BIN_W-1:0]   bin_index;
    } req_t;

    // Packed so that the last field lands in the low bits of m_axis_tdata.
    typedef struct packed {
        logic              seen_any;
        logic [SECT_W-1:0] peak_sector;
        logic [SECT_W-1:0] origin_sector;
        logic [CNT_W-1:0]  fua_count;
        logic [CNT_W-1:0]  sync_count;
        logic [CNT_W-1:0]  bin_count;
    } stats_t;

    typedef struct packed {
        req_t   req;
        logic   typed;
        stats_t want;
    } dir_row_t;

    localparam logic [SECT_W-1:0] LBA_MAX = {SECT_W{1'b1}};

    // Expected results are written as seen, peak, origin, fua, sync, bin.
    localparam dir_row_t DIRECTED_ROWS [23] = '{
        '{'{ilh_pkg::REQ_RD_SIZE, 48'h0, 48'h0, 1'b0, 1'b0, 6'd0}, 1'b1, '0},
        '{'{ilh_pkg::REQ_RD_GAP, 48'h0, 48'h0, 1'b0, 1'b0, 6'd63}, 1'b1, '0},
        '{'{ilh_pkg::REQ_RD_SIZE, 48'h0, 48'h0, 1'b0, 1'b0, 6'd63}, 1'b1, '0},
        '{'{ilh_pkg::REQ_EVENT, 48'h100, 48'h100, 1'b1, 1'b0, 6'd42}, 1'b1,
          '{1'b1, 48'h100, 48'h100, 32'd0, 32'd1, 32'd0}},
        '{'{ilh_pkg::REQ_RD_SIZE, 48'h0, 48'h0, 1'b0, 1'b0, 6'd0}, 1'b1,
          '{1'b1, 48'h100, 48'h100, 32'd0, 32'd1, 32'd1}},
        '{'{ilh_pkg::REQ_RD_GAP, 48'h0, 48'h0, 1'b0, 1'b0, 6'd0}, 1'b1,
          '{1'b1, 48'h100, 48'h100, 32'd0, 32'd1, 32'd1}},
        '{'{ilh_pkg::REQ_EVENT, 48'h100, 48'h101, 1'b0, 1'b1, 6'd21}, 1'b0, '0},
        '{'{ilh_pkg::REQ_EVENT, 48'h200, LBA_MAX, 1'b1, 1'b1, 6'd0}, 1'b0, '0},
        '{'{ilh_pkg::REQ_RD_SIZE, 48'h0, 48'h0, 1'b0, 1'b0, 6'd31}, 1'b0, '0},
        '{'{ilh_pkg::REQ_RD_GAP, 48'h0, 48'h0, 1'b0, 1'b0, 6'd8}, 1'b0, '0},
        '{'{ilh_pkg::REQ_EVENT, 48'h300, 48'h10, 1'b0, 1'b0, 6'd5}, 1'b0, '0},
        '{'{ilh_pkg::REQ_RD_SIZE, 48'h0, 48'h0, 1'b0, 1'b0, 6'd47}, 1'b0, '0},
        '{'{ilh_pkg::REQ_CLEAR, LBA_MAX, LBA_MAX, 1'b1, 1'b1, 6'd63}, 1'b1, '0},
        '{'{ilh_pkg::REQ_RD_GAP, 48'h0, 48'h0, 1'b0, 1'b0, 6'd0}, 1'b1, '0},
        '{'{ilh_pkg::REQ_EVENT, 48'h50, 48'h10, 1'b0, 1'b1, 6'd0}, 1'b0, '0},
        '{'{ilh_pkg::REQ_RD_GAP, 48'h0, 48'h0, 1'b0, 1'b0, 6'd7}, 1'b0, '0},
        '{'{ilh_pkg::REQ_CLEAR, 48'h0, 48'h0, 1'b0, 1'b0, 6'd0}, 1'b1, '0},
        '{'{ilh_pkg::REQ_EVENT, LBA_MAX, LBA_MAX, 1'b1, 1'b1, 6'd63}, 1'b1,
          '{1'b1, LBA_MAX, LBA_MAX, 32'd1, 32'd1, 32'd0}},
        '{'{ilh_pkg::REQ_CLEAR, 48'h0, 48'h0, 1'b0, 1'b0, 6'd0}, 1'b1, '0},
        '{'{ilh_pkg::REQ_EVENT, 48'h0, 48'h1, 1'b0, 1'b0, 6'd0}, 1'b0, '0},
        '{'{ilh_pkg::REQ_EVENT, 48'hC000_0000_0000, 48'hC000_0000_0000,
            1'b1, 1'b0, 6'd0}, 1'b0, '0},
        '{'{ilh_pkg::REQ_RD_GAP, 48'h0, 48'h0, 1'b0, 1'b0, 6'd48}, 1'b0, '0},
        '{'{ilh_pkg::REQ_CLEAR, 48'h0, 48'h0, 1'b0, 1'b0, 6'd0}, 1'b1, '0}
    };

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [199:0] m_axis_tdata;

    // Predicted histogram state.
    logic [CNT_W-1:0]  size_hist [SIZE_BINS];
    logic [CNT_W-1:0]  gap_hist [GAP_BINS];
    logic [SECT_W-1:0] furthest_lba;
    logic [SECT_W-1:0] first_lba;
    logic [CNT_W-1:0]  sync_seen;
    logic [CNT_W-1:0]  fua_seen;
    logic              trace_open;

    stats_t pending_stats [$];

    int  errors;
    int  cycles;
    int  n_events;
    int  n_reads;
    int  n_clears;
    int  n_results;
    bit  src_no_idle;
    bit  sink_no_idle;
    logic [SECT_W-1:0] cursor;

    io_layout_log2_histogram_unit #(
        .SIZE_BINS (SIZE_BINS),
        .GAP_BINS  (GAP_BINS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_stats.size());
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int msb_index(input logic [SECT_W-1:0] v);
        int p;
        p = 0;
        for (int i = SECT_W - 1; i > 0; i--)
        begin
            if (v[i])
            begin
                p = i;
                break;
            end
        end
        return p;
    endfunction

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic void wipe_stats();
        foreach (size_hist[i])
        begin
            size_hist[i] = '0;
        end
        foreach (gap_hist[i])
        begin
            gap_hist[i] = '0;
        end
        furthest_lba = '0;
        first_lba    = '0;
        sync_seen    = '0;
        fua_seen     = '0;
        trace_open   = 1'b0;
    endfunction

    function automatic stats_t histogram_predict(input req_t r);
        stats_t o;
        logic [SECT_W-1:0] len;
        int sb;
        int gb;
        o = '0;
        case (r.kind)
            ilh_pkg::REQ_EVENT:
            begin
                len = r.stop_lba - r.start_lba;
                if (!trace_open)
                begin
                    trace_open   = 1'b1;
                    first_lba    = r.start_lba;
                    furthest_lba = r.stop_lba;
                end
                // A start at or below the furthest end so far is no gap at all.
                if (r.start_lba > furthest_lba)
                begin
                    gb = 1 + msb_index(r.start_lba - furthest_lba);
                    if (gb > GAP_BINS - 1)
                    begin
                        gb = GAP_BINS - 1;
                    end
                end
                else
                begin
                    gb = 0;
                end
                gap_hist[gb] = bump(gap_hist[gb]);
                if (r.is_sync)
                begin
                    sync_seen = bump(sync_seen);
                end
                if (r.is_fua)
                begin
                    fua_seen = bump(fua_seen);
                end
                sb = msb_index(len);
                if (sb > SIZE_BINS - 1)
                begin
                    sb = SIZE_BINS - 1;
                end
                size_hist[sb] = bump(size_hist[sb]);
                if (r.stop_lba > furthest_lba)
                begin
                    furthest_lba = r.stop_lba;
                end
            end
            ilh_pkg::REQ_RD_SIZE:
            begin
                if (r.bin_index < SIZE_BINS)
                begin
                    o.bin_count = size_hist[r.bin_index];
                end
            end
            ilh_pkg::REQ_RD_GAP:
            begin
                if (r.bin_index < GAP_BINS)
                begin
                    o.bin_count = gap_hist[r.bin_index];
                end
            end
            default:
            begin
                wipe_stats();
            end
        endcase
        o.sync_count    = sync_seen;
        o.fua_count     = fua_seen;
        o.origin_sector = first_lba;
        o.peak_sector   = furthest_lba;
        o.seen_any      = trace_open;
        return o;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= PRINT_LIMIT)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    function automatic logic [SECT_W-1:0] rand_lba();
        return SECT_W'({$urandom, $urandom});
    endfunction

    // Magnitude with its top set bit spread evenly over the whole sector range.
    function automatic logic [SECT_W-1:0] rand_span();
        logic [SECT_W-1:0] v;
        int k;
        k = $urandom_range(0, SECT_W);
        if (k == 0)
        begin
            return '0;
        end
        v = rand_lba() >> (SECT_W - k);
        v[k-1] = 1'b1;
        return v;
    endfunction

    // Drives one request, waits for its acceptance and records what it should produce.
    task automatic send_request(input req_t r, input logic typed, input stats_t want);
        int idle;
        stats_t pred;
        idle = src_no_idle ? 0 : $urandom_range(0, 19);
        if (idle > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (idle) @(negedge clk);
        end
        s_axis_tdata  = {r.bin_index, r.is_fua, r.is_sync, r.stop_lba, r.start_lba};
        s_axis_tuser  = r.kind;
        s_axis_tvalid = 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        pred = histogram_predict(r);
        pending_stats.push_back(typed ? want : pred);
        case (r.kind)
            ilh_pkg::REQ_EVENT:  n_events++;
            ilh_pkg::REQ_CLEAR:  n_clears++;
            default:             n_reads++;
        endcase
        @(negedge clk);
    endtask

    function automatic req_t make_random_request();
        req_t r;
        int pick;
        r.is_sync   = 1'($urandom_range(0, 1));
        r.is_fua    = 1'($urandom_range(0, 1));
        r.bin_index = BIN_W'($urandom_range(0, 63));
        r.start_lba = rand_lba();
        r.stop_lba  = rand_lba();
        pick = $urandom_range(0, 99);
        if (pick < 72)
        begin
            r.kind = ilh_pkg::REQ_EVENT;
            // Mostly a sorted trace; now and then a start that lands anywhere.
            case ($urandom_range(0, 9))
                0:       r.start_lba = rand_lba();
                1:       r.start_lba = cursor;
                default: r.start_lba = cursor + rand_span();
            endcase
            cursor = r.start_lba;
            if ($urandom_range(0, 9) == 0)
            begin
                r.stop_lba = r.start_lba - rand_span();
            end
            else
            begin
                r.stop_lba = r.start_lba + rand_span();
            end
        end
        else if (pick < 85)
        begin
            r.kind = ilh_pkg::REQ_RD_SIZE;
        end
        else if (pick < 98)
        begin
            r.kind = ilh_pkg::REQ_RD_GAP;
        end
        else
        begin
            r.kind = ilh_pkg::REQ_CLEAR;
            cursor = rand_span();
        end
        return r;
    endfunction

    // Result side: random stalls, every accepted result compared with the oldest prediction.
    initial
    begin
        int stall;
        stats_t got;
        stats_t want;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = sink_no_idle ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            got = stats_t'(m_axis_tdata[192:0]);
            n_results++;
            if (pending_stats.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing expected, tdata %h", m_axis_tdata));
            end
            else
            begin
                want = pending_stats.pop_front();
                if (got.bin_count !== want.bin_count)
                    report_mismatch($sformatf("bin_count %h, expected %h",
                                              got.bin_count, want.bin_count));
                if (got.sync_count !== want.sync_count)
                    report_mismatch($sformatf("sync_count %h, expected %h",
                                              got.sync_count, want.sync_count));
                if (got.fua_count !== want.fua_count)
                    report_mismatch($sformatf("fua_count %h, expected %h",
                                              got.fua_count, want.fua_count));
                if (got.origin_sector !== want.origin_sector)
                    report_mismatch($sformatf("origin_sector %h, expected %h",
                                              got.origin_sector, want.origin_sector));
                if (got.peak_sector !== want.peak_sector)
                    report_mismatch($sformatf("peak_sector %h, expected %h",
                                              got.peak_sector, want.peak_sector));
                if (got.seen_any !== want.seen_any)
                    report_mismatch($sformatf("seen_any %b, expected %b",
                                              got.seen_any, want.seen_any));
            end
            @(negedge clk);
        end
    end

    initial
    begin
        int drain;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ilh_pkg::REQ_EVENT;
        errors        = 0;
        cycles        = 0;
        n_events      = 0;
        n_reads       = 0;
        n_clears      = 0;
        n_results     = 0;
        src_no_idle   = 1'b0;
        sink_no_idle  = 1'b0;
        cursor        = '0;
        wipe_stats();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            send_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end

        // Each chunk picks its own pacing, so some run with no idling on one or both sides.
        for (int c = 0; c < RAND_CHUNKS; c++)
        begin
            src_no_idle  = ($urandom_range(0, 3) == 0);
            sink_no_idle = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < CHUNK_LEN; n++)
            begin
                send_request(make_random_request(), 1'b0, '0);
            end
        end
        s_axis_tvalid = 1'b0;

        drain = 0;
        while (pending_stats.size() != 0 && drain < 2000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (10) @(posedge clk);

        $display("covered %0d events, %0d bin reads and %0d clears; %0d results checked",
                 n_events, n_reads, n_clears, n_results);
        $display("%0d results still expected, %0d mismatches", pending_stats.size(), errors);
        if (errors == 0 && pending_stats.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
